>>> rtl/core/arcs_pkg.sv
// arcs_pkg: shared types and codes for the adc round-robin channel scanner
// holds event kind codes, controller state type and the command/status structs
// no dependencies
package arcs_pkg;

    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNREGISTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REBUILD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rebuild_step;
        logic emit;
    } arcs_cmd_t;

    typedef struct packed {
        logic unreg_hit;
        logic slot_last;
        logic out_busy;
    } arcs_status_t;

endpackage

>>> rtl/core/arcs_ctrl.sv
// arcs_ctrl: sequencing state machine of the channel scanner
// steps each word through execute, list rebuild (after an unregister that hits) and result load
// depends on arcs_pkg
module arcs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    input  arcs_pkg::arcs_status_t stat,
    output arcs_pkg::arcs_cmd_t    cmd
);
    import arcs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    assign out_free = !stat.out_busy || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        cmd.capture      = 1'b0;
        cmd.exec         = 1'b0;
        cmd.rebuild_step = 1'b0;
        cmd.emit         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.unreg_hit)
                begin
                    state_next = ST_REBUILD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_REBUILD:
            begin
                cmd.rebuild_step = 1'b1;
                if (stat.slot_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/arcs_dp.sv
// arcs_dp: datapath of the channel scanner
// holds enable mask, scan list memory, count, position and the output word
// depends on arcs_pkg, driven by arcs_ctrl
module arcs_dp #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  arcs_pkg::arcs_cmd_t              cmd,
    output arcs_pkg::arcs_status_t           stat,
    input  logic [arcs_pkg::KIND_W-1:0]      kind,
    input  logic [$clog2(NUM_CHANNELS)-1:0]  channel,
    input  logic [SAMPLE_BITS-1:0]           sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             sample_valid,
    output logic [$clog2(NUM_CHANNELS)-1:0]  sample_channel,
    output logic [SAMPLE_BITS-1:0]           sample_value,
    output logic                             start_conversion,
    output logic [$clog2(NUM_CHANNELS)-1:0]  convert_channel,
    output logic                             event_taken,
    output logic [$clog2(NUM_CHANNELS+1)-1:0] active_count
);
    import arcs_pkg::*;

    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
    localparam int MASK_W = 1 << CH_W;

    // control state
    logic [MASK_W-1:0] mask_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CH_W-1:0]   pos_reg;
    logic [CH_W-1:0]   slot_reg;
    logic              out_valid_reg;

    // captured word and staged result
    logic [KIND_W-1:0]      kind_reg;
    logic [CH_W-1:0]        chan_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [CH_W-1:0]        cur_reg;
    logic [CH_W-1:0]        rd_data_reg;
    logic                   res_sval_reg;
    logic [CH_W-1:0]        res_schan_reg;
    logic [SAMPLE_BITS-1:0] res_svalue_reg;
    logic                   res_start_reg;
    logic                   res_conv_sel_reg;
    logic [CH_W-1:0]        res_conv_reg;
    logic                   res_taken_reg;

    // output word
    logic                   sval_reg;
    logic [CH_W-1:0]        schan_reg;
    logic [SAMPLE_BITS-1:0] svalue_reg;
    logic                   start_reg;
    logic [CH_W-1:0]        conv_reg;
    logic                   taken_reg;
    logic [CNT_W-1:0]       count_reg;

    logic [CH_W-1:0] scan_list [NUM_CHANNELS];

    logic              ch_ok;
    logic              ch_on;
    logic              list_full;
    logic              reg_ok;
    logic              unreg_ok;
    logic              done_ok;
    logic [CNT_W-1:0]  pos_inc;
    logic [CH_W-1:0]   next_pos;
    logic [CH_W-1:0]   total_idx;
    logic              wr_en;
    logic [CH_W-1:0]   wr_data;

    assign ch_ok     = CNT_W'(chan_reg) < CNT_W'(NUM_CHANNELS);
    assign ch_on     = mask_reg[chan_reg];
    assign list_full = total_reg == CNT_W'(NUM_CHANNELS);
    assign reg_ok    = (kind_reg == KIND_REGISTER) && ch_ok && !ch_on && !list_full;
    assign unreg_ok  = (kind_reg == KIND_UNREGISTER) && ch_ok && ch_on;
    assign done_ok   = (kind_reg == KIND_DONE) && (total_reg != '0);
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);
    assign next_pos  = (pos_inc >= total_reg) ? '0 : pos_inc[CH_W-1:0];
    assign total_idx = total_reg[CH_W-1:0];

    assign wr_en   = (cmd.exec && reg_ok) || (cmd.rebuild_step && mask_reg[slot_reg]);
    assign wr_data = cmd.exec ? chan_reg : slot_reg;

    assign stat.unreg_hit = unreg_ok;
    assign stat.slot_last = slot_reg == CH_W'(NUM_CHANNELS - 1);
    assign stat.out_busy  = out_valid_reg;

    // scan list memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            scan_list[total_idx] <= wr_data;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= scan_list[next_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            total_reg     <= '0;
            pos_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (kind_reg)
                    KIND_REGISTER:
                    begin
                        if (reg_ok)
                        begin
                            mask_reg  <= mask_reg | (MASK_W'(1) << chan_reg);
                            total_reg <= total_reg + CNT_W'(1);
                            if (total_reg == '0)
                            begin
                                pos_reg <= '0;
                            end
                        end
                    end
                    KIND_UNREGISTER:
                    begin
                        if (unreg_ok)
                        begin
                            mask_reg  <= mask_reg & ~(MASK_W'(1) << chan_reg);
                            total_reg <= '0;
                            pos_reg   <= '0;
                            slot_reg  <= '0;
                        end
                    end
                    KIND_DONE:
                    begin
                        if (done_ok)
                        begin
                            pos_reg <= next_pos;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.rebuild_step)
            begin
                slot_reg <= slot_reg + CH_W'(1);
                if (mask_reg[slot_reg])
                begin
                    total_reg <= total_reg + CNT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            chan_reg <= channel;
            smp_reg  <= sample;
        end
        if (cmd.exec)
        begin
            res_sval_reg     <= 1'b0;
            res_schan_reg    <= '0;
            res_svalue_reg   <= '0;
            res_start_reg    <= 1'b0;
            res_conv_sel_reg <= 1'b0;
            res_conv_reg     <= '0;
            res_taken_reg    <= 1'b0;
            case (kind_reg)
                KIND_REGISTER:
                begin
                    if (reg_ok)
                    begin
                        res_taken_reg <= 1'b1;
                        if (total_reg == '0)
                        begin
                            res_start_reg <= 1'b1;
                            res_conv_reg  <= chan_reg;
                            cur_reg       <= chan_reg;
                        end
                    end
                end
                KIND_UNREGISTER:
                begin
                    if (unreg_ok)
                    begin
                        res_taken_reg <= 1'b1;
                    end
                end
                KIND_DONE:
                begin
                    if (done_ok)
                    begin
                        res_sval_reg     <= 1'b1;
                        res_schan_reg    <= cur_reg;
                        res_svalue_reg   <= smp_reg;
                        res_start_reg    <= 1'b1;
                        res_conv_sel_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // first enabled slot becomes the list head
        if (cmd.rebuild_step && mask_reg[slot_reg] && (total_reg == '0))
        begin
            res_start_reg <= 1'b1;
            res_conv_reg  <= slot_reg;
            cur_reg       <= slot_reg;
        end
        if (cmd.emit)
        begin
            sval_reg   <= res_sval_reg;
            schan_reg  <= res_schan_reg;
            svalue_reg <= res_svalue_reg;
            start_reg  <= res_start_reg;
            conv_reg   <= res_conv_sel_reg ? rd_data_reg : res_conv_reg;
            taken_reg  <= res_taken_reg;
            count_reg  <= total_reg;
            if (res_conv_sel_reg)
            begin
                cur_reg <= rd_data_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign sample_valid     = sval_reg;
    assign sample_channel   = schan_reg;
    assign sample_value     = svalue_reg;
    assign start_conversion = start_reg;
    assign convert_channel  = conv_reg;
    assign event_taken      = taken_reg;
    assign active_count     = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(NUM_CHANNELS))
        else $error("scan count above channel count");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ($countones(mask_reg) == int'(total_reg)))
        else $error("scan count out of step with enable mask");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result load lost");

    a_sample_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sval_reg) |-> start_reg)
        else $error("sample delivered without next conversion");

endmodule

>>> rtl/core/adc_round_robin_channel_scanner.sv
// sequence: a word is accepted in idle, executed, then loaded into the output register
//   in the emit state once that register is free; an unregister that changes the set
//   first rebuilds the scan list, walking one channel slot per cycle through all slots;
//   a new word is accepted only after the previous one has been loaded
// reset: mask, count, position and output valid clear, scan list is not cleared
// top level: arcs_ctrl sequencer and arcs_dp datapath, depends on arcs_pkg
module adc_round_robin_channel_scanner #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [arcs_pkg::KIND_W-1:0]       kind,
    input  logic [$clog2(NUM_CHANNELS)-1:0]   channel,
    input  logic [SAMPLE_BITS-1:0]            sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              sample_valid,
    output logic [$clog2(NUM_CHANNELS)-1:0]   sample_channel,
    output logic [SAMPLE_BITS-1:0]            sample_value,
    output logic                              start_conversion,
    output logic [$clog2(NUM_CHANNELS)-1:0]   convert_channel,
    output logic                              event_taken,
    output logic [$clog2(NUM_CHANNELS+1)-1:0] active_count
);
    import arcs_pkg::*;

    arcs_cmd_t    cmd;
    arcs_status_t stat;

    arcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    arcs_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (kind),
        .channel          (channel),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sample_valid     (sample_valid),
        .sample_channel   (sample_channel),
        .sample_value     (sample_value),
        .start_conversion (start_conversion),
        .convert_channel  (convert_channel),
        .event_taken      (event_taken),
        .active_count     (active_count)
    );

endmodule
